>>> src/assert_macros.svh
// Assertion macros for the checker file of the envelope generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on a given clock, held off while the reset is low.
`define ASSERT_AT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("envelope checker: property failed");

// Check a property on the block clock and reset.
`define ASSERT_STD(label, prop) `ASSERT_AT(label, clk_i, rst_ni, prop)

`endif

>>> src/adsr_pkg.sv
// Shared stage, item kind and register index codes of the envelope generator.
package adsr_pkg;

  localparam logic [2:0] STAGE_IDLE    = 3'd0;
  localparam logic [2:0] STAGE_ATTACK  = 3'd1;
  localparam logic [2:0] STAGE_DECAY   = 3'd2;
  localparam logic [2:0] STAGE_SUSTAIN = 3'd3;
  localparam logic [2:0] STAGE_RELEASE = 3'd4;

  // item kinds
  localparam logic [1:0] KIND_TICK    = 2'd0;
  localparam logic [1:0] KIND_TRIGGER = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;
  localparam logic [1:0] KIND_UNUSED  = 2'd3;

  // register indexes
  localparam logic [2:0] REG_ATTACK   = 3'd0;
  localparam logic [2:0] REG_DECAY    = 3'd1;
  localparam logic [2:0] REG_RELEASE  = 3'd2;
  localparam logic [2:0] REG_SUSTAIN  = 3'd3;
  localparam logic [2:0] REG_MODE     = 3'd4;
  localparam logic [2:0] REG_LOOP     = 3'd5;
  localparam logic [2:0] REG_VEL_SENS = 3'd6;

endpackage

>>> src/adsr_envelope_generator.sv
// Top level of the linear ADSR / ADR envelope generator.
//
// Every item (sample tick, trigger with velocity, or release) gives one result: the level
// and stage after the item. A tick that computes no new slope updates the level, then
// loads the output register in S_FINISH. Any stage entry that needs a slope runs the
// bit-serial restoring divider for a LEVEL_FRAC_BITS+1 bit quotient (25 bits at the
// default), plus an S_MUL multiply for the sustain target; the longest items (a trigger
// or loop retrigger) run both a timed attack and a timed decay division. in_stall_o is
// high from acceptance until the result is loaded into the output register; a result
// waiting on out_stall_i does not block acceptance of the next item. Registers sit on
// the APB port at byte address 4*i.
module adsr_envelope_generator #(
  parameter int LEVEL_FRAC_BITS = 24,
  parameter int LENGTH_BITS     = 24
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input items
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 kind_i,
  input  logic [16:0]                velocity_i,
  // result items
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [LEVEL_FRAC_BITS:0]   level_o,
  output logic [2:0]                 stage_o,
  output logic                       is_idle_o,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [4:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int LVL_W   = LEVEL_FRAC_BITS + 1;
  localparam int SLP_W   = LVL_W + 1;
  localparam int SUM_W   = LVL_W + 2;
  localparam int CNT_W   = $clog2(LVL_W + 1);
  localparam int VEL_SH  = LEVEL_FRAC_BITS - 16;
  localparam int PROD_SH = 32 - LEVEL_FRAC_BITS;

  localparam logic [LVL_W-1:0] ONE_LVL = LVL_W'(64'd1 << LEVEL_FRAC_BITS);
  localparam logic [LVL_W-1:0] THR_LVL = LVL_W'((64'd1 << LEVEL_FRAC_BITS) / 1000);
  localparam logic [16:0]      VEL_FULL = 17'd65536;

  // sequencer states
  localparam logic [3:0] S_READY   = 4'd0;
  localparam logic [3:0] S_TRIG    = 4'd1;
  localparam logic [3:0] S_DIV     = 4'd2;
  localparam logic [3:0] S_DIV_END = 4'd3;
  localparam logic [3:0] S_MUL     = 4'd4;
  localparam logic [3:0] S_DEC_SET = 4'd5;
  localparam logic [3:0] S_FINISH  = 4'd6;

  // what a finished division feeds
  localparam logic [1:0] JOB_ATT = 2'd0;
  localparam logic [1:0] JOB_DEC = 2'd1;
  localparam logic [1:0] JOB_REL = 2'd2;

  // configuration registers
  logic [LENGTH_BITS-1:0] attack_q, decay_q, release_q;
  logic [16:0]            sustain_q;
  logic                   mode_q, loop_q, vel_sens_q;

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q   <= LENGTH_BITS'(480);
      decay_q    <= LENGTH_BITS'(4800);
      release_q  <= LENGTH_BITS'(9600);
      sustain_q  <= 17'd45875;
      mode_q     <= 1'b0;
      loop_q     <= 1'b0;
      vel_sens_q <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        adsr_pkg::REG_ATTACK:   attack_q   <= pwdata[LENGTH_BITS-1:0];
        adsr_pkg::REG_DECAY:    decay_q    <= pwdata[LENGTH_BITS-1:0];
        adsr_pkg::REG_RELEASE:  release_q  <= pwdata[LENGTH_BITS-1:0];
        adsr_pkg::REG_SUSTAIN:  sustain_q  <= pwdata[16:0];
        adsr_pkg::REG_MODE:     mode_q     <= pwdata[0];
        adsr_pkg::REG_LOOP:     loop_q     <= pwdata[0];
        adsr_pkg::REG_VEL_SENS: vel_sens_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (paddr[4:2])
      adsr_pkg::REG_ATTACK:   prdata = 32'(attack_q);
      adsr_pkg::REG_DECAY:    prdata = 32'(decay_q);
      adsr_pkg::REG_RELEASE:  prdata = 32'(release_q);
      adsr_pkg::REG_SUSTAIN:  prdata = 32'(sustain_q);
      adsr_pkg::REG_MODE:     prdata = 32'(mode_q);
      adsr_pkg::REG_LOOP:     prdata = 32'(loop_q);
      adsr_pkg::REG_VEL_SENS: prdata = 32'(vel_sens_q);
      default:                prdata = 32'd0;
    endcase
  end

  // envelope state and sequencer
  logic [3:0]              state_q, state_d;
  logic [2:0]              stage_q, stage_d;
  logic [LVL_W-1:0]        level_q, level_d;
  logic [LVL_W-1:0]        target_q, target_d;
  logic signed [SLP_W-1:0] slope_q, slope_d;
  logic [16:0]             velocity_q, velocity_d;
  logic [1:0]              job_q, job_d;
  logic                    out_valid_q, out_valid_d;

  // datapath registers, no reset needed
  logic [33:0]             prod_q, prod_d;
  logic [LVL_W-1:0]        quo_q, quo_d;
  logic [LENGTH_BITS-1:0]  rem_q, rem_d;
  logic [LENGTH_BITS-1:0]  den_q, den_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic                    neg_q, neg_d;
  logic                    nz_q, nz_d;
  logic [LVL_W-1:0]        out_level_q, out_level_d;
  logic [2:0]              out_stage_q, out_stage_d;
  logic                    out_idle_q, out_idle_d;

  // saturated inputs
  logic [16:0] vel_in_sat, sustain_sat;
  assign vel_in_sat  = (velocity_i > VEL_FULL) ? VEL_FULL : velocity_i;
  assign sustain_sat = (sustain_q > VEL_FULL) ? VEL_FULL : sustain_q;

  // level step with clamp to 0..ONE
  logic signed [SUM_W-1:0] sum;
  logic [LVL_W-1:0]        lv_step;
  always_comb begin
    sum = $signed({2'b00, level_q}) + SUM_W'(slope_q);
    if (sum < 0) begin
      lv_step = '0;
    end else if (sum > $signed({2'b00, ONE_LVL})) begin
      lv_step = ONE_LVL;
    end else begin
      lv_step = sum[LVL_W-1:0];
    end
  end

  // one restoring divider step
  logic [LENGTH_BITS:0] rem_sh, rem_sub;
  logic                 div_ge;
  assign rem_sh  = {rem_q, quo_q[LVL_W-1]};
  assign div_ge  = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  // quotient with the minimum-step rule
  logic [LVL_W-1:0]        q_fix;
  logic signed [SLP_W-1:0] q_pos;
  assign q_fix = (quo_q == '0 && nz_q) ? LVL_W'(1) : quo_q;
  assign q_pos = $signed({1'b0, q_fix});

  // decay target and distance
  logic [LVL_W-1:0] dec_tgt, dec_mag;
  logic             dec_neg;
  assign dec_tgt = mode_q ? '0 : LVL_W'(prod_q >> PROD_SH);
  assign dec_neg = dec_tgt < level_q;
  assign dec_mag = dec_neg ? (level_q - dec_tgt) : (dec_tgt - level_q);

  logic [LVL_W-1:0] peak;
  assign peak = LVL_W'(velocity_q) << VEL_SH;

  always_comb begin
    state_d     = state_q;
    stage_d     = stage_q;
    level_d     = level_q;
    target_d    = target_q;
    slope_d     = slope_q;
    velocity_d  = velocity_q;
    job_d       = job_q;
    out_valid_d = out_valid_q && out_stall_i;
    prod_d      = prod_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    den_d       = den_q;
    cnt_d       = cnt_q;
    neg_d       = neg_q;
    nz_d        = nz_q;
    out_level_d = out_level_q;
    out_stage_d = out_stage_q;
    out_idle_d  = out_idle_q;

    case (state_q)
      S_READY: begin
        if (in_valid_i) begin
          state_d = S_FINISH;
          case (kind_i)
            adsr_pkg::KIND_TICK: begin
              case (stage_q)
                adsr_pkg::STAGE_ATTACK: begin
                  if (lv_step >= target_q) begin
                    level_d = target_q;
                    state_d = S_MUL;
                  end else begin
                    level_d = lv_step;
                  end
                end
                adsr_pkg::STAGE_DECAY: begin
                  level_d = lv_step;
                  if (!mode_q) begin
                    if (slope_q[SLP_W-1] && lv_step <= target_q) begin
                      level_d = target_q;
                      stage_d = adsr_pkg::STAGE_SUSTAIN;
                      slope_d = '0;
                    end
                  end else if (lv_step <= THR_LVL) begin
                    level_d = '0;
                    if (loop_q) begin
                      velocity_d = vel_sens_q ? velocity_q : VEL_FULL;
                      state_d    = S_TRIG;
                    end else begin
                      stage_d = adsr_pkg::STAGE_IDLE;
                    end
                  end
                end
                adsr_pkg::STAGE_SUSTAIN: begin
                  level_d = target_q;
                end
                adsr_pkg::STAGE_RELEASE: begin
                  level_d = lv_step;
                  if (lv_step <= THR_LVL) begin
                    level_d = '0;
                    if (mode_q && loop_q) begin
                      velocity_d = vel_sens_q ? velocity_q : VEL_FULL;
                      state_d    = S_TRIG;
                    end else begin
                      stage_d = adsr_pkg::STAGE_IDLE;
                    end
                  end
                end
                default: begin
                  stage_d = adsr_pkg::STAGE_IDLE;
                  level_d = '0;
                end
              endcase
            end
            adsr_pkg::KIND_TRIGGER: begin
              velocity_d = vel_sens_q ? vel_in_sat : VEL_FULL;
              state_d    = S_TRIG;
            end
            adsr_pkg::KIND_RELEASE: begin
              if (stage_q != adsr_pkg::STAGE_IDLE && stage_q != adsr_pkg::STAGE_RELEASE) begin
                stage_d  = adsr_pkg::STAGE_RELEASE;
                target_d = '0;
                if (release_q == '0) begin
                  level_d = '0;
                  slope_d = '0;
                  stage_d = adsr_pkg::STAGE_IDLE;
                end else begin
                  quo_d   = level_q;
                  rem_d   = '0;
                  den_d   = release_q;
                  cnt_d   = CNT_W'(LVL_W);
                  neg_d   = 1'b1;
                  nz_d    = level_q != '0;
                  job_d   = JOB_REL;
                  state_d = S_DIV;
                end
              end
            end
            default: ;
          endcase
        end
      end

      // start the attack from zero
      S_TRIG: begin
        stage_d  = adsr_pkg::STAGE_ATTACK;
        target_d = peak;
        level_d  = '0;
        if (attack_q == '0) begin
          level_d = peak;
          state_d = S_MUL;
        end else begin
          quo_d   = peak;
          rem_d   = '0;
          den_d   = attack_q;
          cnt_d   = CNT_W'(LVL_W);
          neg_d   = 1'b0;
          nz_d    = peak != '0;
          job_d   = JOB_ATT;
          state_d = S_DIV;
        end
      end

      // shift in one quotient bit
      S_DIV: begin
        rem_d = div_ge ? rem_sub[LENGTH_BITS-1:0] : rem_sh[LENGTH_BITS-1:0];
        quo_d = {quo_q[LVL_W-2:0], div_ge};
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          state_d = S_DIV_END;
        end
      end

      // apply the new slope
      S_DIV_END: begin
        state_d = S_FINISH;
        case (job_q)
          JOB_ATT: begin
            slope_d = q_pos;
            if (q_fix >= target_q) begin
              level_d = target_q;
              state_d = S_MUL;
            end else begin
              level_d = q_fix;
            end
          end
          JOB_DEC: slope_d = neg_q ? -q_pos : q_pos;
          JOB_REL: slope_d = -q_pos;
          default: ;
        endcase
      end

      // sustain scaled by velocity
      S_MUL: begin
        prod_d  = 34'(sustain_sat) * 34'(velocity_q);
        state_d = S_DEC_SET;
      end

      // enter decay
      S_DEC_SET: begin
        stage_d  = adsr_pkg::STAGE_DECAY;
        target_d = dec_tgt;
        if (decay_q == '0) begin
          level_d = dec_tgt;
          slope_d = '0;
          if (!mode_q) begin
            stage_d = adsr_pkg::STAGE_SUSTAIN;
          end
          state_d = S_FINISH;
        end else begin
          quo_d   = dec_mag;
          rem_d   = '0;
          den_d   = decay_q;
          cnt_d   = CNT_W'(LVL_W);
          neg_d   = dec_neg;
          nz_d    = dec_mag != '0;
          job_d   = JOB_DEC;
          state_d = S_DIV;
        end
      end

      // hand the result to the output register once it is free
      S_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_level_d = level_q;
          out_stage_d = stage_q;
          out_idle_d  = (stage_q == adsr_pkg::STAGE_IDLE) && (level_q <= THR_LVL);
          out_valid_d = 1'b1;
          state_d     = S_READY;
        end
      end

      default: state_d = S_READY;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_READY;
      stage_q     <= adsr_pkg::STAGE_IDLE;
      level_q     <= '0;
      target_q    <= '0;
      slope_q     <= '0;
      velocity_q  <= VEL_FULL;
      job_q       <= JOB_ATT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stage_q     <= stage_d;
      level_q     <= level_d;
      target_q    <= target_d;
      slope_q     <= slope_d;
      velocity_q  <= velocity_d;
      job_q       <= job_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q      <= prod_d;
    quo_q       <= quo_d;
    rem_q       <= rem_d;
    den_q       <= den_d;
    cnt_q       <= cnt_d;
    neg_q       <= neg_d;
    nz_q        <= nz_d;
    out_level_q <= out_level_d;
    out_stage_q <= out_stage_d;
    out_idle_q  <= out_idle_d;
  end

  assign in_stall_o  = state_q != S_READY;
  assign out_valid_o = out_valid_q;
  assign level_o     = out_level_q;
  assign stage_o     = out_stage_q;
  assign is_idle_o   = out_idle_q;

endmodule

>>> src/adsr_checker.sv
// Port-level checker for the envelope generator, bound to the top level.
`include "assert_macros.svh"

module adsr_checker #(
  parameter int LEVEL_FRAC_BITS = 24
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic [LEVEL_FRAC_BITS:0] level_o,
  input logic [2:0]               stage_o,
  input logic                     is_idle_o
);

  localparam logic [LEVEL_FRAC_BITS:0] ONE_LVL = (LEVEL_FRAC_BITS + 1)'(64'd1 << LEVEL_FRAC_BITS);

  // a stalled result holds
  `ASSERT_STD(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(level_o) && $stable(stage_o))

  // one item at a time: the input closes right after an item is taken
  `ASSERT_STD(a_busy_after_accept, in_valid_i && !in_stall_o |=> in_stall_o)

  // idle flag only with the idle stage
  `ASSERT_STD(a_idle_stage, out_valid_o && is_idle_o |-> stage_o == adsr_pkg::STAGE_IDLE)

  // level never exceeds full scale
  `ASSERT_STD(a_level_range, out_valid_o |-> level_o <= ONE_LVL)

endmodule

bind adsr_envelope_generator adsr_checker #(
  .LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)
) u_adsr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .level_o     (level_o),
  .stage_o     (stage_o),
  .is_idle_o   (is_idle_o)
);

>>> test/tb.sv
// Self-checking testbench for the linear ADSR / ADR envelope generator.
`timescale 1ns / 1ps

module tb;

  localparam longint ENV_ONE = 64'sd1 << 24;
  localparam longint ENV_THR = ENV_ONE / 1000;
  localparam logic [16:0] VEL_FULL = 17'd65536;

  typedef struct {
    logic [24:0] level;
    logic [2:0]  stage;
    logic        idle;
  } env_result_t;

  // Track the envelope state and compare every result with its expectation.
  class envelope_scoreboard;
    bit [23:0] attack_len, decay_len, release_len;
    bit [16:0] sustain_cfg;
    bit        adr_mode, loop_on, vel_scaled;
    logic [2:0] stage_q;
    longint    level_q, target_q, slope_q;
    bit [16:0] vel_q;
    env_result_t expected_q[$];
    int mismatches, checked;
    int n_ticks, n_triggers, n_releases, n_unused, n_settings;

    function new();
      attack_len  = 24'd480;
      decay_len   = 24'd4800;
      release_len = 24'd9600;
      sustain_cfg = 17'd45875;
      adr_mode    = 1'b0;
      loop_on     = 1'b0;
      vel_scaled  = 1'b0;
      stage_q     = adsr_pkg::STAGE_IDLE;
      level_q     = 0;
      target_q    = 0;
      slope_q     = 0;
      vel_q       = VEL_FULL;
      n_settings  = 1;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        adsr_pkg::REG_ATTACK:   attack_len  = val[23:0];
        adsr_pkg::REG_DECAY:    decay_len   = val[23:0];
        adsr_pkg::REG_RELEASE:  release_len = val[23:0];
        adsr_pkg::REG_SUSTAIN:  sustain_cfg = val[16:0];
        adsr_pkg::REG_MODE:     adr_mode    = val[0];
        adsr_pkg::REG_LOOP:     loop_on     = val[0];
        adsr_pkg::REG_VEL_SENS: vel_scaled  = val[0];
        default: ;
      endcase
    endfunction

    function bit [16:0] sat_vel(bit [16:0] v);
      return (v > VEL_FULL) ? VEL_FULL : v;
    endfunction

    function longint clamp_lvl(longint x);
      if (x < 0) return 0;
      if (x > ENV_ONE) return ENV_ONE;
      return x;
    endfunction

    function longint slope_over(longint len, longint from_lvl, longint to_lvl);
      longint d, q;
      if (len == 0) return 0;
      d = to_lvl - from_lvl;
      q = d / len;
      if (q == 0 && d != 0) q = (d > 0) ? 1 : -1;
      return q;
    endfunction

    function void enter_decay();
      longint s;
      stage_q = adsr_pkg::STAGE_DECAY;
      s = longint'(sat_vel(sustain_cfg));
      target_q = adr_mode ? 0 : ((s * longint'(vel_q)) >>> 8);
      if (decay_len == 0) begin
        level_q = target_q;
        slope_q = 0;
        if (!adr_mode) stage_q = adsr_pkg::STAGE_SUSTAIN;
      end else begin
        slope_q = slope_over(longint'(decay_len), level_q, target_q);
      end
    endfunction

    function void start_note(bit [16:0] vel);
      vel_q    = vel_scaled ? vel : VEL_FULL;
      stage_q  = adsr_pkg::STAGE_ATTACK;
      level_q  = 0;
      target_q = longint'(vel_q) << 8;
      if (attack_len == 0) begin
        level_q = target_q;
        enter_decay();
        return;
      end
      slope_q = slope_over(longint'(attack_len), 0, target_q);
      level_q = clamp_lvl(level_q + slope_q);
      if (level_q >= target_q) begin
        level_q = target_q;
        enter_decay();
      end
    endfunction

    function void start_release();
      if (stage_q == adsr_pkg::STAGE_IDLE || stage_q == adsr_pkg::STAGE_RELEASE) return;
      stage_q  = adsr_pkg::STAGE_RELEASE;
      target_q = 0;
      if (release_len == 0) begin
        level_q = 0;
        slope_q = 0;
        stage_q = adsr_pkg::STAGE_IDLE;
      end else begin
        slope_q = slope_over(longint'(release_len), level_q, 0);
      end
    endfunction

    function void hit_zero(bit retrig);
      level_q = 0;
      if (retrig) start_note(vel_q);
      else stage_q = adsr_pkg::STAGE_IDLE;
    endfunction

    function void advance_sample();
      case (stage_q)
        adsr_pkg::STAGE_ATTACK: begin
          level_q = clamp_lvl(level_q + slope_q);
          if (level_q >= target_q) begin
            level_q = target_q;
            enter_decay();
          end
        end
        adsr_pkg::STAGE_DECAY: begin
          level_q = clamp_lvl(level_q + slope_q);
          if (!adr_mode) begin
            if (slope_q < 0 && level_q <= target_q) begin
              level_q = target_q;
              stage_q = adsr_pkg::STAGE_SUSTAIN;
              slope_q = 0;
            end
          end else if (level_q <= ENV_THR) begin
            hit_zero(loop_on);
          end
        end
        adsr_pkg::STAGE_SUSTAIN: level_q = target_q;
        adsr_pkg::STAGE_RELEASE: begin
          level_q = clamp_lvl(level_q + slope_q);
          if (level_q <= ENV_THR) hit_zero(adr_mode && loop_on);
        end
        default: begin
          stage_q = adsr_pkg::STAGE_IDLE;
          level_q = 0;
        end
      endcase
    endfunction

    // Apply one accepted item and queue the result it should give.
    function void note_item(logic [1:0] kind, logic [16:0] vel);
      env_result_t r;
      case (kind)
        adsr_pkg::KIND_TICK: begin
          n_ticks++;
          advance_sample();
        end
        adsr_pkg::KIND_TRIGGER: begin
          n_triggers++;
          start_note(sat_vel(vel));
        end
        adsr_pkg::KIND_RELEASE: begin
          n_releases++;
          start_release();
        end
        default: n_unused++;
      endcase
      r.level = 25'(clamp_lvl(level_q));
      r.stage = stage_q;
      r.idle  = (stage_q == adsr_pkg::STAGE_IDLE) && (level_q <= ENV_THR);
      expected_q.push_back(r);
    endfunction

    // Compare one accepted result with the oldest expectation.
    function void check_result(logic [24:0] level, logic [2:0] stage, logic idle);
      env_result_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: level %0d stage %0d idle %0d", level, stage, idle);
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (level !== e.level || stage !== e.stage || idle !== e.idle) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch on result %0d: expected level %0d stage %0d idle %0d",
                   checked, e.level, e.stage, e.idle);
          $display("  got level %0d stage %0d idle %0d", level, stage, idle);
        end
      end
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [1:0]  kind_i      = adsr_pkg::KIND_TICK;
  logic [16:0] velocity_i  = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [24:0] level_o;
  logic [2:0]  stage_o;
  logic        is_idle_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [4:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  envelope_scoreboard sb = new();

  bit gaps_on  = 1'b1;
  bit stall_on = 1'b1;
  int stall_left = 0;
  int items_sent = 0;
  int tick_span  = 8;

  adsr_envelope_generator DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (kind_i),
    .velocity_i (velocity_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .level_o    (level_o),
    .stage_o    (stage_o),
    .is_idle_o  (is_idle_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #5 clk_i = ~clk_i;

  // Pick an idle gap: mostly none or short, a few long.
  function automatic int pick_gap(bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Stall the result side in bursts.
  always @(posedge clk_i) begin
    if (!stall_on) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if (out_stall_i) begin
      out_stall_i <= 1'b0;
      stall_left = $urandom_range(0, 6);
    end else begin
      stall_left = pick_gap(1'b1);
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end
    end
  end

  // Observe both handshakes.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_item(kind_i, velocity_i);
      if (out_valid_o && !out_stall_i) sb.check_result(level_o, stage_o, is_idle_o);
    end
  end

  task automatic send_item(input logic [1:0] kind, input logic [16:0] vel);
    int gap;
    gap = pick_gap(gaps_on);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    velocity_i <= vel;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(adsr_pkg::KIND_TICK, 17'($urandom));
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  // Drop valid and hold until every expected result has come out.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_all(input logic [31:0] att, input logic [31:0] dec,
                           input logic [31:0] rel, input logic [31:0] sus,
                           input bit mode, input bit lp, input bit vs);
    reg_write(adsr_pkg::REG_ATTACK, att);
    reg_write(adsr_pkg::REG_DECAY, dec);
    reg_write(adsr_pkg::REG_RELEASE, rel);
    reg_write(adsr_pkg::REG_SUSTAIN, sus);
    reg_write(adsr_pkg::REG_MODE, {31'd0, mode});
    reg_write(adsr_pkg::REG_LOOP, {31'd0, lp});
    reg_write(adsr_pkg::REG_VEL_SENS, {31'd0, vs});
    sb.n_settings++;
  endtask

  function automatic logic [31:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 32'd0;
    if (r < 80) return $urandom_range(1, 12);
    if (r < 95) return $urandom_range(13, 200);
    if (r < 98) return 32'h00FF_FFFF;
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_sustain();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'd0;
    if (r == 1) return 32'd65536;
    if (r == 2) return $urandom_range(65537, 131071);
    return $urandom_range(0, 65536);
  endfunction

  function automatic logic [16:0] pick_vel();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 17'd0;
    if (r == 1) return VEL_FULL;
    if (r == 2) return 17'($urandom);
    return 17'($urandom_range(0, 65536));
  endfunction

  // One note: trigger, ticks, usually a release, ticks, sometimes noise.
  task automatic play_note();
    send_item(adsr_pkg::KIND_TRIGGER, pick_vel());
    send_ticks($urandom_range(0, 2 * tick_span + 3));
    if ($urandom_range(0, 99) < 85) send_item(adsr_pkg::KIND_RELEASE, 17'($urandom));
    send_ticks($urandom_range(0, 2 * tick_span + 3));
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 4)) send_item(2'($urandom), 17'($urandom));
    end
  endtask

  initial begin
    logic [31:0] att, dec, rel;
    int stop_at;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings, idle cases, release in attack, unused kind.
    send_item(adsr_pkg::KIND_TICK, 17'd0);
    send_item(adsr_pkg::KIND_UNUSED, 17'h1FFFF);
    send_item(adsr_pkg::KIND_RELEASE, 17'd0);
    send_item(adsr_pkg::KIND_TRIGGER, 17'h1FFFF);
    send_ticks(2);
    send_item(adsr_pkg::KIND_RELEASE, 17'd0);
    send_item(adsr_pkg::KIND_RELEASE, 17'd0);
    send_ticks(1);
    drain();

    // Directed: instant stages, full sustain, velocity scaling and saturation.
    write_all(32'h5A00_0000, 32'd0, 32'd0, 32'd65536, 1'b0, 1'b0, 1'b1);
    send_item(adsr_pkg::KIND_TRIGGER, 17'd0);
    send_ticks(1);
    send_item(adsr_pkg::KIND_RELEASE, 17'd0);
    send_item(adsr_pkg::KIND_TRIGGER, 17'h1FFFF);
    send_ticks(1);
    send_item(adsr_pkg::KIND_RELEASE, 17'd0);
    drain();

    // Directed: ADR looping with instant stages, sustain saturation.
    write_all(32'd0, 32'd0, 32'd0, 32'h1FFFF, 1'b1, 1'b1, 1'b1);
    send_item(adsr_pkg::KIND_TRIGGER, 17'd40000);
    send_ticks(2);
    send_item(adsr_pkg::KIND_RELEASE, 17'd0);
    drain();

    // Directed: longest lengths, tiny velocity gives a minimum slope.
    write_all(32'h00FF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF, 32'd0, 1'b0, 1'b0, 1'b1);
    send_item(adsr_pkg::KIND_TRIGGER, 17'd1);
    send_ticks(2);
    send_item(adsr_pkg::KIND_RELEASE, 17'd0);
    send_ticks(1);
    drain();

    // Random phases, each with fresh settings and idling pattern.
    for (int ph = 0; ph < 8; ph++) begin
      att = pick_len();
      dec = pick_len();
      rel = pick_len();
      write_all(att, dec, rel, pick_sustain(), 1'($urandom), 1'($urandom), 1'($urandom));
      tick_span = 1;
      if (att[23:0] < 40 && att[23:0] > tick_span) tick_span = int'(att[23:0]);
      if (dec[23:0] < 40 && dec[23:0] > tick_span) tick_span = int'(dec[23:0]);
      if (rel[23:0] < 40 && rel[23:0] > tick_span) tick_span = int'(rel[23:0]);
      gaps_on  = (ph != 3) && (ph % 4 != 1);
      stall_on = (ph != 3) && (ph % 4 != 2);
      stop_at = items_sent + 250;
      while (items_sent < stop_at) play_note();
      drain();
    end

    repeat (60) @(posedge clk_i);
    $display("covered %0d items (%0d ticks, %0d triggers, %0d releases, %0d unused kinds)",
             items_sent, sb.n_ticks, sb.n_triggers, sb.n_releases, sb.n_unused);
    $display("over %0d register settings, %0d results checked, %0d mismatches",
             sb.n_settings, sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // End a hung run.
  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
